>>> src/assert_macros.svh
// Assertion macros shared by the pose box bounds files.
// Depends on nothing; users provide clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define PBB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PBB_ASSERT_KNOWN(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(sig)) \
    else $error(msg);
`endif

>>> src/pbb_pkg.sv
// Shared widths, register codes and the matrix entry rounding for pose box bounds.
// Depends on nothing.
package pbb_pkg;
  localparam int COORD_WIDTH    = 32;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int CORNER_COUNT   = 8;
  localparam int QUAT_WIDTH     = 16;
  localparam int PROD_W  = 2 * QUAT_WIDTH;
  localparam int MSUM_W  = PROD_W + 3;
  localparam int MAT_W   = QUAT_FRAC_BITS + 5;
  localparam int MPROD_W = MAT_W + COORD_WIDTH;
  localparam int DSUM_W  = MPROD_W + 2;
  localparam int RND_W   = DSUM_W - QUAT_FRAC_BITS;
  localparam int WIDE_W  = RND_W + 1;
  localparam int HALF_UNIT = 32768;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_RADIUS     = 3'd1,
    REG_MIN_X      = 3'd2,
    REG_MIN_Y      = 3'd3,
    REG_MIN_Z      = 3'd4,
    REG_MAX_X      = 3'd5,
    REG_MAX_Y      = 3'd6,
    REG_MAX_Z      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [MAT_W-1:0] val;
    logic                    sat;
  } mat_ent_t;

  function automatic mat_ent_t round_ent(logic signed [MSUM_W-1:0] x);
    logic signed [MSUM_W-1:0] r;
    logic signed [MSUM_W-1:0] lim;
    mat_ent_t e;
    lim = MSUM_W'(64'sd8 <<< QUAT_FRAC_BITS);
    r = (x + MSUM_W'(64'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    e.sat = 1'b0;
    if (r > lim) begin
      r = lim;
      e.sat = 1'b1;
    end else if (r < -lim) begin
      r = -lim;
      e.sat = 1'b1;
    end
    e.val = MAT_W'(r);
    return e;
  endfunction
endpackage

>>> src/pbb_axis.sv
// One world axis: matrix row times the box extents, smallest and largest sums.
// Depends on pbb_pkg.
module pbb_axis (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [pbb_pkg::MAT_W-1:0]       row_i [3],
  input  logic signed [pbb_pkg::COORD_WIDTH-1:0] lo_i  [3],
  input  logic signed [pbb_pkg::COORD_WIDTH-1:0] hi_i  [3],
  output logic signed [pbb_pkg::DSUM_W-1:0]      smin_o,
  output logic signed [pbb_pkg::DSUM_W-1:0]      smax_o
);
  logic signed [pbb_pkg::MPROD_W-1:0] plo_q [3];
  logic signed [pbb_pkg::MPROD_W-1:0] phi_q [3];
  logic signed [pbb_pkg::DSUM_W-1:0]  smin_d, smax_d, smin_q, smax_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= pbb_pkg::MPROD_W'(row_i[j]) * pbb_pkg::MPROD_W'(lo_i[j]);
        phi_q[j] <= pbb_pkg::MPROD_W'(row_i[j]) * pbb_pkg::MPROD_W'(hi_i[j]);
      end
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

  always_comb begin
    smin_d = '0;
    smax_d = '0;
    for (int j = 0; j < 3; j++) begin
      if (plo_q[j] < phi_q[j]) begin
        smin_d = smin_d + pbb_pkg::DSUM_W'(plo_q[j]);
        smax_d = smax_d + pbb_pkg::DSUM_W'(phi_q[j]);
      end else begin
        smin_d = smin_d + pbb_pkg::DSUM_W'(phi_q[j]);
        smax_d = smax_d + pbb_pkg::DSUM_W'(plo_q[j]);
      end
    end
  end

  assign smin_o = smin_q;
  assign smax_o = smax_q;
endmodule

>>> src/pose_box_bounds_core.sv
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o   pos_*_i, quat_*_i
// out      out_valid_o / out_stall_i world_min_*_o, world_max_*_o, saturated_o
// cfg      cfg_we_i                  cfg_idx_i, cfg_data_i
// Five register stages: quaternion products, matrix entries, entry-extent products,
// extent sums, then rounding, translation and clamping. One beat per cycle while no
// result waits under stall; each accepted beat passes through the stages in that order.
// The whole pipeline advances together; it holds when a result waits under stall.
// Reset clears the valid bits and the configuration registers.
// Depends on pbb_pkg, pbb_axis and assert_macros.svh.
`include "assert_macros.svh"
module pose_box_bounds_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [pbb_pkg::COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [pbb_pkg::COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [pbb_pkg::COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [pbb_pkg::QUAT_WIDTH-1:0] quat_x_i,
  input  logic signed [pbb_pkg::QUAT_WIDTH-1:0] quat_y_i,
  input  logic signed [pbb_pkg::QUAT_WIDTH-1:0] quat_z_i,
  input  logic signed [pbb_pkg::QUAT_WIDTH-1:0] quat_w_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_min_x_o,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_min_y_o,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_min_z_o,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_max_x_o,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_max_y_o,
  output logic signed [pbb_pkg::COORD_WIDTH-1:0] world_max_z_o,
  output logic saturated_o
);
  localparam int CW = pbb_pkg::COORD_WIDTH;
  localparam int PW = pbb_pkg::PROD_W;
  localparam int SW = pbb_pkg::MSUM_W;
  localparam int WW = pbb_pkg::WIDE_W;
  localparam int DW = pbb_pkg::DSUM_W;
  localparam logic signed [WW-1:0] CMAX = {{(WW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [WW-1:0] CMIN = ~CMAX;

  logic                 shape_q;
  logic [CW-2:0]        radius_q;
  logic signed [CW-1:0] lmin_q [3];
  logic signed [CW-1:0] lmax_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= 1'b0;
      radius_q <= '0;
      for (int a = 0; a < 3; a++) begin
        lmin_q[a] <= '0;
        lmax_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (pbb_pkg::cfg_reg_e'(cfg_idx_i))
        pbb_pkg::REG_SHAPE_MODE: shape_q   <= cfg_data_i[0];
        pbb_pkg::REG_RADIUS:     radius_q  <= cfg_data_i[CW-2:0];
        pbb_pkg::REG_MIN_X:      lmin_q[0] <= cfg_data_i[CW-1:0];
        pbb_pkg::REG_MIN_Y:      lmin_q[1] <= cfg_data_i[CW-1:0];
        pbb_pkg::REG_MIN_Z:      lmin_q[2] <= cfg_data_i[CW-1:0];
        pbb_pkg::REG_MAX_X:      lmax_q[0] <= cfg_data_i[CW-1:0];
        pbb_pkg::REG_MAX_Y:      lmax_q[1] <= cfg_data_i[CW-1:0];
        pbb_pkg::REG_MAX_Z:      lmax_q[2] <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (shape_q) begin
        lo[a] = -$signed({1'b0, radius_q});
        hi[a] = $signed({1'b0, radius_q});
      end else begin
        lo[a] = lmin_q[a];
        hi[a] = lmax_q[a];
      end
    end
  end

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  assign adv        = !vo_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [CW:0]   pos1_q [3];
  logic signed [CW:0]   pos2_q [3];
  logic signed [CW:0]   pos3_q [3];
  logic signed [CW:0]   pos4_q [3];
  logic signed [pbb_pkg::MAT_W-1:0] mat_q [9];
  logic sat2_q, sat3_q, sat4_q;
  pbb_pkg::mat_ent_t ent [9];
  logic signed [SW-1:0] msum [9];
  logic sat2_d;

  always_comb begin
    msum[0] = SW'(ww_q) + SW'(xx_q) - SW'(yy_q) - SW'(zz_q);
    msum[1] = (SW'(xy_q) - SW'(wz_q)) <<< 1;
    msum[2] = (SW'(xz_q) + SW'(wy_q)) <<< 1;
    msum[3] = (SW'(xy_q) + SW'(wz_q)) <<< 1;
    msum[4] = SW'(ww_q) - SW'(xx_q) + SW'(yy_q) - SW'(zz_q);
    msum[5] = (SW'(yz_q) - SW'(wx_q)) <<< 1;
    msum[6] = (SW'(xz_q) - SW'(wy_q)) <<< 1;
    msum[7] = (SW'(yz_q) + SW'(wx_q)) <<< 1;
    msum[8] = SW'(ww_q) - SW'(xx_q) - SW'(yy_q) + SW'(zz_q);
    sat2_d = 1'b0;
    for (int i = 0; i < 9; i++) begin
      ent[i] = pbb_pkg::round_ent(msum[i]);
      sat2_d = sat2_d | ent[i].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ww_q <= PW'(quat_w_i) * PW'(quat_w_i);
      xx_q <= PW'(quat_x_i) * PW'(quat_x_i);
      yy_q <= PW'(quat_y_i) * PW'(quat_y_i);
      zz_q <= PW'(quat_z_i) * PW'(quat_z_i);
      xy_q <= PW'(quat_x_i) * PW'(quat_y_i);
      xz_q <= PW'(quat_x_i) * PW'(quat_z_i);
      yz_q <= PW'(quat_y_i) * PW'(quat_z_i);
      wx_q <= PW'(quat_w_i) * PW'(quat_x_i);
      wy_q <= PW'(quat_w_i) * PW'(quat_y_i);
      wz_q <= PW'(quat_w_i) * PW'(quat_z_i);
      pos1_q[0] <= (CW+1)'(pos_x_i);
      pos1_q[1] <= (CW+1)'(pos_y_i) - (shape_q ? (CW+1)'(pbb_pkg::HALF_UNIT) : '0);
      pos1_q[2] <= (CW+1)'(pos_z_i);
      for (int i = 0; i < 9; i++) mat_q[i] <= ent[i].val;
      sat2_q <= sat2_d;
      sat3_q <= sat2_q;
      sat4_q <= sat3_q;
      pos2_q <= pos1_q;
      pos3_q <= pos2_q;
      pos4_q <= pos3_q;
    end
  end

  logic signed [DW-1:0] smin [3];
  logic signed [DW-1:0] smax [3];
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [pbb_pkg::MAT_W-1:0] row [3];
    assign row[0] = mat_q[3*a];
    assign row[1] = mat_q[3*a+1];
    assign row[2] = mat_q[3*a+2];
    pbb_axis u_axis (
      .clk_i (clk_i),
      .en_i  (adv),
      .row_i (row),
      .lo_i  (lo),
      .hi_i  (hi),
      .smin_o(smin[a]),
      .smax_o(smax[a])
    );
  end

  logic signed [CW-1:0] wmin_d [3];
  logic signed [CW-1:0] wmax_d [3];
  logic signed [CW-1:0] wmin_q [3];
  logic signed [CW-1:0] wmax_q [3];
  logic signed [DW-1:0] rmin, rmax;
  logic signed [WW-1:0] fmin, fmax;
  logic sato_d, sato_q;

  always_comb begin
    sato_d = sat4_q;
    for (int a = 0; a < 3; a++) begin
      rmin = (smin[a] + DW'(64'sd1 <<< (pbb_pkg::QUAT_FRAC_BITS - 1)))
             >>> pbb_pkg::QUAT_FRAC_BITS;
      rmax = (smax[a] + DW'(64'sd1 <<< (pbb_pkg::QUAT_FRAC_BITS - 1)))
             >>> pbb_pkg::QUAT_FRAC_BITS;
      fmin = WW'(rmin) + WW'(pos4_q[a]);
      fmax = WW'(rmax) + WW'(pos4_q[a]);
      if (fmin < CMIN) begin
        wmin_d[a] = CW'(CMIN);
        sato_d = 1'b1;
      end else if (fmin > CMAX) begin
        wmin_d[a] = CW'(CMAX);
        sato_d = 1'b1;
      end else begin
        wmin_d[a] = CW'(fmin);
      end
      if (fmax > CMAX) begin
        wmax_d[a] = CW'(CMAX);
        sato_d = 1'b1;
      end else if (fmax < CMIN) begin
        wmax_d[a] = CW'(CMIN);
        sato_d = 1'b1;
      end else begin
        wmax_d[a] = CW'(fmax);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wmin_q <= wmin_d;
      wmax_q <= wmax_d;
      sato_q <= sato_d;
    end
  end

  assign out_valid_o   = vo_q;
  assign world_min_x_o = wmin_q[0];
  assign world_min_y_o = wmin_q[1];
  assign world_min_z_o = wmin_q[2];
  assign world_max_x_o = wmax_q[0];
  assign world_max_y_o = wmax_q[1];
  assign world_max_z_o = wmax_q[2];
  assign saturated_o   = sato_q;

  `PBB_ASSERT(a_take_enters, in_valid_i && !in_stall_o |=> v1_q, "accepted beat lost at entry")
  `PBB_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "stall without waiting beat")
  `PBB_ASSERT(a_order_x, out_valid_o |-> world_min_x_o <= world_max_x_o, "x bounds out of order")
  `PBB_ASSERT(a_order_y, out_valid_o |-> world_min_y_o <= world_max_y_o, "y bounds out of order")
  `PBB_ASSERT_KNOWN(a_valid_known, out_valid_o, "result valid is unknown")
endmodule
